/* src/tmrr_pkg.sv */
package tmrr_pkg;

    localparam int unsigned ADDR_FIELD_BITS = 13;
    localparam int unsigned WORD_BITS       = 64;
    localparam int unsigned ENTRY_BITS      = 16;
    localparam int unsigned ROW_BITS        = 3;
    localparam int unsigned CFG_INDEX_BITS  = 1;

    localparam logic [ROW_BITS-1:0] LAST_ROW = 3'd7;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_EIGHT_BIT_MODE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PACKED_OUTPUT  = 1'd1;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_RENDER = 1'b1;

    localparam int unsigned XFLIP_BIT = 10;
    localparam int unsigned YFLIP_BIT = 11;
    localparam int unsigned BANK_LSB  = 12;

    typedef struct packed {
        logic                load_we;
        logic                capture;
        logic                rd_en;
        logic [ROW_BITS-1:0] row;
    } t_cmd;

    typedef struct packed {
        logic s1_ready;
    } t_stat;

endpackage

/* src/tile_map_row_renderer_top.sv */
// Tile map row renderer.
// Input channel (i_in_valid / o_in_stall) takes one request per handshake.
// A load request (action 0) writes i_tile_word into the tile store at
// i_word_address in the cycle it is accepted; it produces no result.
// A render request (action 1) reads the tile named by i_map_entry and
// returns its eight pixel rows, row 0 first, on the output channel
// (o_out_valid / i_out_stall), with o_last_row set on row 7.
// Rows come from the single read port of the tile store, one row per cycle
// while the receiver does not stall: each row read fills the read stage,
// then the row is formatted into the output register. A load leaves the
// sequencer idle; o_in_stall stays high until a render's 8 row reads issue.
// When the receiver stalls, the output register and the read stage hold
// their rows and row reads pause until space frees up.
// Configuration (i_cfg_we, i_cfg_index, i_cfg_data) sets 8bpp mode and
// packed 4-bit output; write it only while the block is idle.
// Reset clears the sequencer, the pipeline valids and both configuration
// registers; the tile store is not cleared and must be loaded before use.
module tile_map_row_renderer_top
    import tmrr_pkg::*;
#(
    parameter int unsigned STORE_WORDS      = 8192,
    parameter int unsigned TILE_NUMBER_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic                       i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_action,
    input  logic [ADDR_FIELD_BITS-1:0] i_word_address,
    input  logic [WORD_BITS-1:0]       i_tile_word,
    input  logic [ENTRY_BITS-1:0]      i_map_entry,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [WORD_BITS-1:0]       o_pixel_row,
    output logic [ROW_BITS-1:0]        o_row_number,
    output logic                       o_last_row
);

    t_cmd  cmd;
    t_stat stat;

    tmrr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    tmrr_datapath #(
        .STORE_WORDS      (STORE_WORDS),
        .TILE_NUMBER_BITS (TILE_NUMBER_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_word_address (i_word_address),
        .i_tile_word    (i_tile_word),
        .i_map_entry    (i_map_entry),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_row    (o_pixel_row),
        .o_row_number   (o_row_number),
        .o_last_row     (o_last_row)
    );

endmodule

/* src/tmrr_ctrl.sv */
module tmrr_ctrl
    import tmrr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_action,
    input  t_stat i_stat,
    output logic  o_in_stall,
    output t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state              r_state, n_state;
    logic [ROW_BITS-1:0] r_row, n_row;
    logic                accept;

    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state       = r_state;
        n_row         = r_row;
        o_cmd.load_we = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.rd_en   = 1'b0;
        o_cmd.row     = r_row;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_RENDER) begin
                        o_cmd.capture = 1'b1;
                        n_row         = '0;
                        n_state       = ST_RUN;
                    end else begin
                        o_cmd.load_we = 1'b1;
                    end
                end
            end
            ST_RUN: begin
                if (i_stat.s1_ready) begin
                    o_cmd.rd_en = 1'b1;
                    n_row       = r_row + 1'b1;
                    if (r_row == LAST_ROW) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_row   <= '0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
        end
    end

    a_rd_only_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_en |-> (r_state == ST_RUN))
        else $error("row read issued outside run state");

    a_render_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_RENDER) |=> (r_state == ST_RUN && r_row == '0))
        else $error("render request did not start the row sequence");

    a_last_row_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.rd_en && r_row == LAST_ROW) |=> (r_state == ST_IDLE))
        else $error("sequencer did not stop after the last row");

endmodule

/* src/tmrr_datapath.sv */
module tmrr_datapath
    import tmrr_pkg::*;
#(
    parameter int unsigned STORE_WORDS      = 8192,
    parameter int unsigned TILE_NUMBER_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cmd                       i_cmd,
    output t_stat                      o_stat,
    input  logic                       i_cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  logic                       i_cfg_data,
    input  logic [ADDR_FIELD_BITS-1:0] i_word_address,
    input  logic [WORD_BITS-1:0]       i_tile_word,
    input  logic [ENTRY_BITS-1:0]      i_map_entry,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic [WORD_BITS-1:0]       o_pixel_row,
    output logic [ROW_BITS-1:0]        o_row_number,
    output logic                       o_last_row
);

    localparam int unsigned AW = $clog2(STORE_WORDS);
    localparam int unsigned EW = (AW > ADDR_FIELD_BITS) ? AW : ADDR_FIELD_BITS;

    logic [WORD_BITS-1:0] mem [STORE_WORDS];

    logic                 r_eight_bit_mode;
    logic                 r_packed_output;
    logic [ENTRY_BITS-1:0] r_entry;

    logic                 r_s1_vld, n_s1_vld;
    logic [WORD_BITS-1:0] r_rdata;
    logic [ROW_BITS-1:0]  r_s1_row;
    logic                 r_s1_half;
    logic                 r_s1_xflip;
    logic [3:0]           r_s1_bank;
    logic                 r_s1_mode8;
    logic                 r_s1_packed;

    logic                 r_o_valid, n_o_valid;
    logic [WORD_BITS-1:0] r_pixel_row;
    logic [ROW_BITS-1:0]  r_row_number;
    logic                 r_last_row;

    logic [TILE_NUMBER_BITS-1:0] tile;
    logic [ROW_BITS-1:0]         sy;
    logic [ADDR_FIELD_BITS-1:0]  raddr_field;
    logic [EW-1:0]               raddr_ext;
    logic [EW-1:0]               waddr_ext;
    logic [AW-1:0]               raddr;
    logic [AW-1:0]               waddr;
    logic                        s2_ready;
    logic                        s1_ready;
    logic                        s1_move;
    logic [31:0]                 half;
    logic [WORD_BITS-1:0]        row_fmt;

    assign tile = r_entry[TILE_NUMBER_BITS-1:0];
    assign sy   = r_entry[YFLIP_BIT] ? (i_cmd.row ^ LAST_ROW) : i_cmd.row;

    always_comb begin
        if (r_eight_bit_mode) begin
            raddr_field = ADDR_FIELD_BITS'({tile, sy});
        end else begin
            raddr_field = ADDR_FIELD_BITS'({tile, sy[2:1]});
        end
    end

    assign raddr_ext = EW'(raddr_field);
    assign waddr_ext = EW'(i_word_address);
    assign raddr     = raddr_ext[AW-1:0];
    assign waddr     = waddr_ext[AW-1:0];

    assign s2_ready        = !r_o_valid || !i_out_stall;
    assign s1_ready        = !r_s1_vld || s2_ready;
    assign s1_move         = r_s1_vld && s2_ready;
    assign o_stat.s1_ready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            mem[waddr] <= i_tile_word;
        end
        if (i_cmd.rd_en) begin
            r_rdata <= mem[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eight_bit_mode <= 1'b0;
            r_packed_output  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_EIGHT_BIT_MODE: r_eight_bit_mode <= i_cfg_data;
                CFG_PACKED_OUTPUT:  r_packed_output  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_entry <= i_map_entry;
        end
        if (i_cmd.rd_en) begin
            r_s1_row    <= i_cmd.row;
            r_s1_half   <= sy[0];
            r_s1_xflip  <= r_entry[XFLIP_BIT];
            r_s1_bank   <= r_entry[BANK_LSB +: 4];
            r_s1_mode8  <= r_eight_bit_mode;
            r_s1_packed <= r_packed_output && !r_eight_bit_mode;
        end
    end

    always_comb begin
        n_s1_vld = r_s1_vld;
        if (i_cmd.rd_en) begin
            n_s1_vld = 1'b1;
        end else if (s1_move) begin
            n_s1_vld = 1'b0;
        end
    end

    assign half = r_s1_half ? r_rdata[63:32] : r_rdata[31:0];

    always_comb begin
        logic [2:0] px;
        logic [2:0] sx;
        logic [3:0] nib;
        row_fmt = '0;
        for (int k = 0; k < 8; k++) begin
            px  = 3'(k);
            sx  = r_s1_xflip ? (px ^ LAST_ROW) : px;
            nib = half[{sx, 2'b00} +: 4];
            if (r_s1_mode8) begin
                row_fmt[8*k +: 8] = r_rdata[{sx, 3'b000} +: 8];
            end else if (r_s1_packed) begin
                row_fmt[8*(k/2) + ((k % 2 == 1) ? 0 : 4) +: 4] = nib;
            end else begin
                row_fmt[8*k +: 8] = {r_s1_bank, nib};
            end
        end
    end

    always_comb begin
        n_o_valid = r_o_valid;
        if (s1_move) begin
            n_o_valid = 1'b1;
        end else if (r_o_valid && !i_out_stall) begin
            n_o_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_pixel_row  <= row_fmt;
            r_row_number <= r_s1_row;
            r_last_row   <= (r_s1_row == LAST_ROW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_o_valid <= n_o_valid;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_pixel_row  = r_pixel_row;
    assign o_row_number = r_row_number;
    assign o_last_row   = r_last_row;

    a_read_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_en |-> s1_ready)
        else $error("row read issued while read stage is full");

    a_last_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_last_row == (r_row_number == LAST_ROW)))
        else $error("last row flag does not match row number");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !s2_ready) |=> (r_s1_vld && $stable(r_rdata) && $stable(r_s1_row)))
        else $error("read stage lost data while output was blocked");

endmodule
